// ===== src/gcpb_pkg.sv =====
`timescale 1ns / 1ps

package gcpb_pkg;

	localparam int unsigned CHAN_W = 5;
	localparam int unsigned COLOR_W = 15;
	localparam int unsigned PIXEL_W = 16;
	localparam int unsigned COV_W = 3;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 5'h1f;

	localparam logic [1:0] CFG_IDX_SHIFT = 2'd0;
	localparam logic [1:0] CFG_IDX_WIDTH = 2'd1;
	localparam logic [1:0] CFG_IDX_COLOR = 2'd2;

	localparam logic [1:0] SHIFT_RESET = 2'd2;
	localparam logic [7:0] WIDTH_RESET = 8'd8;
	localparam logic [COLOR_W-1:0] COLOR_RESET = 15'd0;

	typedef struct packed {
		logic [1:0] cov_bits;
		logic [7:0] cell_pitch;
		logic [COLOR_W-1:0] draw_color;
	} cfg_t;

	// Exact floor(x / 3) for any 8-bit x.
	function automatic logic [6:0] div3_u8(input logic [7:0] x);
		logic [16:0] p;
		p = {9'd0, x} * 17'd171;
		return p[15:9];
	endfunction

	// Exact floor(x / 7) for any 8-bit x.
	function automatic logic [5:0] div7_u8(input logic [7:0] x);
		logic [18:0] p;
		p = {11'd0, x} * 19'd293;
		return p[16:11];
	endfunction

endpackage

// ===== src/gcpb_cfg_regs.sv =====
`timescale 1ns / 1ps

module gcpb_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [14:0]         cfg_data,
	output gcpb_pkg::cfg_t      cfg
);
	import gcpb_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cov_bits <= SHIFT_RESET;
			cfg_q.cell_pitch <= WIDTH_RESET;
			cfg_q.draw_color <= COLOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_IDX_SHIFT: cfg_q.cov_bits <= cfg_data[1:0];
				CFG_IDX_WIDTH: cfg_q.cell_pitch <= cfg_data[7:0];
				CFG_IDX_COLOR: cfg_q.draw_color <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== src/gcpb_coverage.sv =====
`timescale 1ns / 1ps

module gcpb_coverage (
	input  logic [1:0]                  cov_bits,
	input  logic [7:0]                  cell_pitch,
	input  logic [7:0]                  glyph_byte,
	input  logic [7:0]                  column,
	input  logic [7:0]                  row,
	output logic [gcpb_pkg::COV_W-1:0]  cov,
	output logic [gcpb_pkg::COV_W-1:0]  cov_max
);
	import gcpb_pkg::*;

	logic [COV_W-1:0] idx_lo;
	logic [COV_W-1:0] field_sel;
	logic [4:0]       bit_pos;
	logic [7:0]       shifted;
	logic [5:0]       row_prod;

	// Only the low three bits of the pixel index can select a field.
	always_comb begin
		cov_max = COV_W'((4'd1 << cov_bits) - 4'd1);
		row_prod = {3'd0, row[2:0]} * {3'd0, cell_pitch[2:0]};
		idx_lo = row_prod[2:0] + column[2:0];
		field_sel = cov_max - (idx_lo & cov_max);
		bit_pos = {3'd0, cov_bits} * {2'd0, field_sel};
		shifted = glyph_byte >> bit_pos;
		cov = shifted[COV_W-1:0] & cov_max;
	end

endmodule

// ===== src/gcpb_channel_mix.sv =====
`timescale 1ns / 1ps

module gcpb_channel_mix (
	input  logic [gcpb_pkg::CHAN_W-1:0] tgt,
	input  logic [gcpb_pkg::CHAN_W-1:0] src,
	input  logic [gcpb_pkg::COV_W-1:0]  cov,
	input  logic [gcpb_pkg::COV_W-1:0]  cov_max,
	output logic [gcpb_pkg::CHAN_W-1:0] mixed
);
	import gcpb_pkg::*;

	logic [7:0] tgt_prod;
	logic [7:0] src_prod;
	logic [6:0] tgt_term;
	logic [6:0] src_term;
	logic [7:0] sum;

	// A partial blend only occurs with a maximum of three or seven.
	always_comb begin
		tgt_prod = {3'd0, tgt} * {5'd0, COV_W'(cov_max - cov)};
		src_prod = {3'd0, src} * {5'd0, cov};
		tgt_term = cov_max[2] ? {1'b0, div7_u8(tgt_prod)} : div3_u8(tgt_prod);
		src_term = div3_u8(src_prod);
		sum = {1'b0, tgt_term} + {1'b0, src_term};
		mixed = (sum > {3'd0, CHAN_MAX}) ? CHAN_MAX : sum[CHAN_W-1:0];
	end

endmodule

// ===== src/glyph_coverage_pixel_blend.sv =====
`timescale 1ns / 1ps

// Anti-aliased RGB555 glyph blend, one pixel per clock while the output is not
// stalled. A transaction on the input channel is registered, blended in one pass
// of combinational logic and presented from the result register; throughput is
// one transaction per cycle while the output is not stalled, set by the input
// register and the result register, and the input accepts one more transaction
// while a finished result is stalled before it stalls in turn.
// Every accepted pixel gives exactly one result, with write_enable low and
// the target pixel passed unchanged when coverage is zero. cfg_ready is
// always high; configuration must be written only while no transaction is in
// flight.
module glyph_coverage_pixel_blend (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  glyph_byte,
	input  logic [7:0]  column,
	input  logic [7:0]  row,
	input  logic [15:0] target_pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_out,
	output logic        write_enable
);
	import gcpb_pkg::*;

	cfg_t cfg;

	logic              valid_s1;
	logic [7:0]        glyph_byte_s1;
	logic [7:0]        column_s1;
	logic [7:0]        row_s1;
	logic [PIXEL_W-1:0] target_s1;

	logic              valid_s2;
	logic [PIXEL_W-1:0] pixel_s2;
	logic              we_s2;

	logic              adv_out;
	logic              in_take;
	logic [COV_W-1:0]  cov;
	logic [COV_W-1:0]  cov_max;
	logic [CHAN_W-1:0] mix_r;
	logic [CHAN_W-1:0] mix_g;
	logic [CHAN_W-1:0] mix_b;
	logic [PIXEL_W-1:0] pixel_next;
	logic              we_next;

	gcpb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign adv_out = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_out;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			glyph_byte_s1 <= glyph_byte;
			column_s1 <= column;
			row_s1 <= row;
			target_s1 <= target_pixel;
		end
	end

	gcpb_coverage u_coverage (
		.cov_bits   (cfg.cov_bits),
		.cell_pitch (cfg.cell_pitch),
		.glyph_byte (glyph_byte_s1),
		.column     (column_s1),
		.row        (row_s1),
		.cov        (cov),
		.cov_max    (cov_max)
	);

	gcpb_channel_mix u_mix_r (
		.tgt     (target_s1[4:0]),
		.src     (cfg.draw_color[4:0]),
		.cov     (cov),
		.cov_max (cov_max),
		.mixed   (mix_r)
	);

	gcpb_channel_mix u_mix_g (
		.tgt     (target_s1[9:5]),
		.src     (cfg.draw_color[9:5]),
		.cov     (cov),
		.cov_max (cov_max),
		.mixed   (mix_g)
	);

	gcpb_channel_mix u_mix_b (
		.tgt     (target_s1[14:10]),
		.src     (cfg.draw_color[14:10]),
		.cov     (cov),
		.cov_max (cov_max),
		.mixed   (mix_b)
	);

	always_comb begin
		if (cov == '0) begin
			pixel_next = target_s1;
			we_next = 1'b0;
		end else if (cov == cov_max) begin
			pixel_next = {1'b1, cfg.draw_color};
			we_next = 1'b1;
		end else begin
			pixel_next = {1'b1, mix_b, mix_g, mix_r};
			we_next = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_out) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_out) begin
			pixel_s2 <= pixel_next;
			we_s2 <= we_next;
		end
	end

	assign out_valid = valid_s2;
	assign pixel_out = pixel_s2;
	assign write_enable = we_s2;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled while the pipeline had room");

	a_stage_moves_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_out) |=> out_valid)
		else $error("registered transaction did not reach the result register");

	a_written_pixel_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_enable) |-> pixel_out[15])
		else $error("written pixel lacks its marker bit");
`endif

endmodule

// ===== tb/sv/glyph_coverage_pixel_blend_tb.sv =====
`timescale 1ns / 1ps

module glyph_coverage_pixel_blend_tb;
	import gcpb_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned END_CYCLES = 12;
	localparam int unsigned HOLD_CYCLES = 150;
	localparam int unsigned HOLD_ITEMS = 40;
	localparam int unsigned RANDOM_PHASES = 10;
	localparam int unsigned ITEMS_PER_PHASE = 100;
	localparam int unsigned SRC_DIVISOR = 3;
	localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic we;
	} blend_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [COLOR_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] glyph_byte = '0;
	logic [7:0] column = '0;
	logic [7:0] row = '0;
	logic [PIXEL_W-1:0] target_pixel = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PIXEL_W-1:0] pixel_out;
	logic write_enable;

	logic [1:0] cur_shift = SHIFT_RESET;
	logic [7:0] cur_width = WIDTH_RESET;
	logic [COLOR_W-1:0] cur_color = COLOR_RESET;

	blend_result_t expected_blends[$];
	int unsigned mismatch_count = 0;
	int unsigned results_checked = 0;
	int unsigned writes_seen = 0;
	int unsigned settings_count = 0;
	int unsigned quiet_cycles = 0;

	bit hold_request = 1'b0;
	int unsigned hold_left = 0;
	int unsigned window_left = 0;
	int unsigned stall_pct = 0;

	glyph_coverage_pixel_blend u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.glyph_byte(glyph_byte),
		.column(column),
		.row(row),
		.target_pixel(target_pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_out(pixel_out),
		.write_enable(write_enable)
	);

	always #5 clk = ~clk;

	function automatic blend_result_t predict_blend(input logic [7:0] bm, input logic [7:0] col,
			input logic [7:0] rw, input logic [PIXEL_W-1:0] tgt);
		int unsigned maxc, idx, pos, cov, t, s, v;
		logic [PIXEL_W-1:0] px;
		blend_result_t res;
		maxc = (32'd1 << cur_shift) - 32'd1;
		idx = 32'(rw) * 32'(cur_width) + 32'(col);
		pos = 32'(cur_shift) * (maxc - (idx & maxc));
		cov = (32'(bm) >> pos) & maxc;
		px = '0;
		if (cov == 0) begin
			res.pixel = tgt;
			res.we = 1'b0;
		end else if (cov == maxc) begin
			res.pixel = {1'b1, cur_color};
			res.we = 1'b1;
		end else begin
			for (int ch = 0; ch < 3; ch++) begin
				t = (32'(tgt) >> (CHAN_W * ch)) & 32'(CHAN_MAX);
				s = (32'(cur_color) >> (CHAN_W * ch)) & 32'(CHAN_MAX);
				v = t * (maxc - cov) / maxc + s * cov / SRC_DIVISOR;
				if (v > 32'(CHAN_MAX))
					v = 32'(CHAN_MAX);
				px[CHAN_W * ch +: CHAN_W] = v[CHAN_W-1:0];
			end
			res.pixel = {1'b1, px[COLOR_W-1:0]};
			res.we = 1'b1;
		end
		return res;
	endfunction

	function automatic logic [7:0] pick_coord();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, 15));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 30)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// Expects to be called right after a rising edge; returns at the edge that accepts the item.
	task automatic send_pixel(input logic [7:0] bm, input logic [7:0] col, input logic [7:0] rw,
			input logic [PIXEL_W-1:0] tgt);
		in_valid <= 1'b1;
		glyph_byte <= bm;
		column <= col;
		row <= rw;
		target_pixel <= tgt;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		expected_blends.push_back(predict_blend(bm, col, rw, tgt));
	endtask

	task automatic rest_sender(input int unsigned cycles);
		in_valid <= 1'b0;
		repeat (cycles)
			@(posedge clk);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_blends.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [COLOR_W-1:0] data);
		wait_for_drain();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
		CFG_IDX_SHIFT: cur_shift = data[1:0];
		CFG_IDX_WIDTH: cur_width = data[7:0];
		CFG_IDX_COLOR: cur_color = data;
		default: ;
		endcase
	endtask

	// Unused upper data bits carry random junk so that the register masking is exercised.
	task automatic apply_settings(input logic [1:0] shift, input logic [7:0] width,
			input logic [COLOR_W-1:0] color);
		write_reg(CFG_IDX_SHIFT, {13'($urandom), shift});
		write_reg(CFG_IDX_WIDTH, {7'($urandom), width});
		write_reg(CFG_IDX_COLOR, color);
		settings_count++;
	endtask

	task automatic test_reset_settings();
		send_pixel(8'h1B, 8'd0, 8'd0, 16'h7FFF);
		send_pixel(8'h1B, 8'd1, 8'd0, 16'hFFFF);
		send_pixel(8'h1B, 8'd2, 8'd0, 16'h4210);
		send_pixel(8'h1B, 8'd3, 8'd0, 16'h1234);
		send_pixel(8'hE4, 8'd7, 8'd2, 16'h8000);
	endtask

	task automatic test_field_extremes();
		apply_settings(2'd2, 8'd255, 15'h7FFF);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		send_pixel(8'h00, 8'h00, 8'h00, 16'h0000);
		send_pixel(8'h55, 8'd2, 8'd0, 16'h0000);
		send_pixel(8'hAA, 8'd1, 8'd0, 16'h7FFF);
		send_pixel(8'h6C, 8'd255, 8'd1, 16'hA5A5);
		apply_settings(2'd1, 8'd1, 15'h2B6D);
		send_pixel(8'h80, 8'd0, 8'd0, 16'hFFFF);
		send_pixel(8'h01, 8'd7, 8'd0, 16'h0000);
		send_pixel(8'h01, 8'd3, 8'd3, 16'h5A5A);
	endtask

	// Three-bit coverage can push the source term past the channel maximum.
	task automatic test_special_cases();
		apply_settings(2'd3, 8'd1, 15'h7FFF);
		send_pixel(8'hFF, 8'd7, 8'd0, 16'h0000);
		send_pixel(8'hFF, 8'd5, 8'd0, 16'h7FFF);
		send_pixel(8'h05, 8'd7, 8'd0, 16'h0421);
		send_pixel(8'hFF, 8'd4, 8'd0, 16'h1234);
		send_pixel(8'h08, 8'd6, 8'd0, 16'h0000);
		apply_settings(2'd0, 8'd255, 15'h5555);
		send_pixel(8'hFF, 8'd0, 8'd0, 16'hABCD);
		send_pixel(8'hFF, 8'd255, 8'd255, 16'hFFFF);
		apply_settings(2'd2, 8'd0, 15'h03E0);
		send_pixel(8'h1B, 8'd3, 8'd200, 16'h0000);
		send_pixel(8'h1B, 8'd1, 8'd255, 16'h7C1F);
		write_reg(CFG_IDX_UNUSED, 15'h7FFF);
		send_pixel(8'h1B, 8'd2, 8'd9, 16'h3DEF);
	endtask

	task automatic test_output_holdoff();
		apply_settings(2'd2, 8'($urandom_range(1, 255)), 15'($urandom));
		hold_request = 1'b1;
		repeat (HOLD_ITEMS)
			send_pixel(8'($urandom), pick_coord(), pick_coord(), 16'($urandom));
		wait_for_drain();
	endtask

	task automatic test_random_blends();
		int unsigned remaining, burst, gap;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
			0: apply_settings(2'd2, 8'd8, 15'($urandom));
			1: apply_settings(2'd1, 8'd255, 15'h7FFF);
			2: apply_settings(2'd2, 8'd1, 15'h0000);
			3: apply_settings(2'd3, 8'($urandom_range(0, 255)), 15'($urandom));
			4: apply_settings(2'd0, 8'($urandom_range(0, 255)), 15'($urandom));
			5: apply_settings(2'd2, 8'd0, 15'($urandom));
			default: apply_settings(2'($urandom_range(1, 2)), 8'($urandom_range(1, 255)),
					15'($urandom));
			endcase
			remaining = ITEMS_PER_PHASE;
			while (remaining > 0) begin
				burst = $urandom_range(1, 24);
				if (burst > remaining)
					burst = remaining;
				repeat (burst)
					send_pixel(8'($urandom), pick_coord(), pick_coord(), 16'($urandom));
				remaining -= burst;
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0)
					rest_sender(gap);
			end
		end
	endtask

	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (window_left == 0) begin
			window_left = $urandom_range(16, 200);
			case ($urandom_range(0, 4))
			0, 1: stall_pct = 0;
			2: stall_pct = 20;
			3: stall_pct = 50;
			default: stall_pct = 85;
			endcase
		end
		window_left--;
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(negedge clk) begin
		blend_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_blends.size() == 0) begin
				report_mismatch($sformatf("unexpected result pixel_out=%h write_enable=%b",
						pixel_out, write_enable));
			end else begin
				want = expected_blends.pop_front();
				if (pixel_out !== want.pixel)
					report_mismatch($sformatf("pixel_out %h, expected %h", pixel_out, want.pixel));
				if (write_enable !== want.we)
					report_mismatch($sformatf("write_enable %b, expected %b", write_enable,
							want.we));
				results_checked++;
				if (want.we)
					writes_seen++;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("glyph_coverage_pixel_blend_tb: errors");
			$finish;
		end
	end

	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_field_extremes();
		test_special_cases();
		test_output_holdoff();
		test_random_blends();
		wait_for_drain();
		repeat (END_CYCLES)
			@(posedge clk);
		if (expected_blends.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_blends.size()));
		$display("Checked %0d blended pixels, %0d written and %0d passed through,",
				results_checked, writes_seen, results_checked - writes_seen);
		$display("over %0d register settings spanning shifts 0 to 3 and widths 0 to 255.",
				settings_count);
		if (mismatch_count == 0)
			$display("glyph_coverage_pixel_blend_tb: clean");
		else
			$display("glyph_coverage_pixel_blend_tb: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/gcpb_pkg.sv
src/gcpb_cfg_regs.sv
src/gcpb_coverage.sv
src/gcpb_channel_mix.sv
src/glyph_coverage_pixel_blend.sv
tb/sv/glyph_coverage_pixel_blend_tb.sv
